@@ rtl/deq_pkg.sv @@
// ---------------------------------------------------------------------------
// deq_pkg: shared types for the positional-insert deque
// Command kinds, result status codes, per-cell shift controls and the
// sequencer states used by the cell chain and its controller.
// ---------------------------------------------------------------------------
package deq_pkg;

  // One stored element
  typedef logic signed [31:0] word_t;

  // Command carried by an input word
  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_INSERT_POS = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_POP_BACK   = 3'd4,
    KIND_DUMP       = 3'd5
  } kind_t;

  // Result status
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // What a cell loads this cycle
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_FROM_PREV = 2'd1,
    CELL_FROM_NEXT = 2'd2,
    CELL_LOAD      = 2'd3
  } cell_op_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

endpackage

@@ rtl/deq_cell.sv @@
// ---------------------------------------------------------------------------
// deq_cell: one storage cell of the deque chain
// Holds one element and, as told, keeps it, takes its front-side or
// back-side neighbor's element, or loads the broadcast word.
// ---------------------------------------------------------------------------
module deq_cell (
  input  logic              clk,
  input  deq_pkg::cell_op_t op,
  input  deq_pkg::word_t    prev_word,
  input  deq_pkg::word_t    next_word,
  input  deq_pkg::word_t    load_word,
  output deq_pkg::word_t    word
);

  deq_pkg::word_t word_r;
  deq_pkg::word_t word_nxt;

  // source select
  always_comb begin
    case (op)
      deq_pkg::CELL_HOLD:      word_nxt = word_r;
      deq_pkg::CELL_FROM_PREV: word_nxt = prev_word;
      deq_pkg::CELL_FROM_NEXT: word_nxt = next_word;
      deq_pkg::CELL_LOAD:      word_nxt = load_word;
      default:                 word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

@@ rtl/deque_with_positional_insert_top.sv @@
// ---------------------------------------------------------------------------
// deque_with_positional_insert_top: bounded deque with positional insert
// Ordered store of up to CAPACITY signed 32-bit elements in a shifting
// chain of cells.
// ---------------------------------------------------------------------------
// Push front, push back, insert at position, pop front and pop back each take
// one input word and give one result word; the cell chain updates in the same
// cycle, so these commands are accepted one per cycle while the output
// register drains. A dump gives one result per stored element (one result
// with status empty when the store is empty) and holds off new input while
// it streams: the chain rotates by one cell per result word, the first dump
// word is registered from the dump state rather than on acceptance, and no
// new command is taken until the last dump word has left the dump state.
// Element 0 is the front. Occupancy reports the element count after the
// command, low five bits. Inserts into a full store return status full
// (a bad position wins over full) and change nothing.
// ---------------------------------------------------------------------------
module deque_with_positional_insert_top #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic signed [31:0] in_value,
  input  logic [7:0]  in_position,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic signed [31:0] out_element,
  output logic [4:0]  out_occupancy,
  output logic        out_last
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  deq_pkg::state_t  st_r, st_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;

  logic             out_valid_r, out_valid_nxt;
  deq_pkg::status_t out_status_r, out_status_nxt;
  deq_pkg::word_t   out_element_r, out_element_nxt;
  logic [4:0]       out_occupancy_r, out_occupancy_nxt;
  logic             out_last_r, out_last_nxt;

  deq_pkg::word_t    cell_word [CAPACITY];
  deq_pkg::cell_op_t cell_op   [CAPACITY];
  deq_pkg::word_t    load_bus;

  logic             out_free;
  logic             accept;
  deq_pkg::kind_t   kind;
  logic [CW-1:0]    cnt_m1;
  logic [7:0]       pos_m1;
  logic [7:0]       cnt8;
  logic [7:0]       idx8;
  logic [CW-1:0]    ins_idx;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((st_r == deq_pkg::S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign kind     = deq_pkg::kind_t'(in_kind);
  assign cnt_m1   = count_r - CW'(1);

  // position insert index: min(position-1, count)
  assign pos_m1 = in_position - 8'd1;
  assign cnt8   = 8'(count_r);
  assign idx8   = (pos_m1 < cnt8) ? pos_m1 : cnt8;

  always_comb begin
    case (kind)
      deq_pkg::KIND_PUSH_FRONT: ins_idx = '0;
      deq_pkg::KIND_PUSH_BACK:  ins_idx = count_r;
      default:                  ins_idx = CW'(idx8);
    endcase
  end

  // cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    deq_pkg::word_t prev_w, next_w;
    if (g == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_prev
      assign prev_w = cell_word[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign next_w = '0;
    end else begin : g_next
      assign next_w = cell_word[g+1];
    end
    deq_cell u_cell (
      .clk       (clk),
      .op        (cell_op[g]),
      .prev_word (prev_w),
      .next_word (next_w),
      .load_word (load_bus),
      .word      (cell_word[g])
    );
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      deq_pkg::S_IDLE: begin
        if (accept && kind == deq_pkg::KIND_DUMP && count_r != '0) st_nxt = deq_pkg::S_DUMP;
      end
      deq_pkg::S_DUMP: begin
        if (out_free && rem_r == CW'(1)) st_nxt = deq_pkg::S_IDLE;
      end
      default: st_nxt = deq_pkg::S_IDLE;
    endcase
  end

  // datapath and result control
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) cell_op[i] = deq_pkg::CELL_HOLD;
    load_bus          = in_value;
    count_nxt         = count_r;
    rem_nxt           = rem_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_status_nxt    = out_status_r;
    out_element_nxt   = out_element_r;
    out_occupancy_nxt = out_occupancy_r;
    out_last_nxt      = out_last_r;

    case (st_r)
      deq_pkg::S_IDLE: begin
        if (accept) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = deq_pkg::ST_OK;
          out_element_nxt = '0;
          out_last_nxt    = 1'b1;
          case (kind)
            deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK,
            deq_pkg::KIND_INSERT_POS: begin
              if (kind == deq_pkg::KIND_INSERT_POS && in_position == 8'd0) begin
                out_status_nxt = deq_pkg::ST_BADPOS;
              end else if (count_r >= CW'(CAPACITY)) begin
                out_status_nxt = deq_pkg::ST_FULL;
              end else begin
                // open a gap at ins_idx and drop the word in
                for (int i = 0; i < CAPACITY; i++) begin
                  if (CW'(i) == ins_idx) cell_op[i] = deq_pkg::CELL_LOAD;
                  else if (CW'(i) > ins_idx && CW'(i) <= count_r)
                    cell_op[i] = deq_pkg::CELL_FROM_PREV;
                end
                count_nxt = count_r + CW'(1);
              end
            end
            deq_pkg::KIND_POP_FRONT: begin
              if (count_r == '0) begin
                out_status_nxt = deq_pkg::ST_EMPTY;
              end else begin
                out_element_nxt = cell_word[0];
                for (int i = 0; i < CAPACITY - 1; i++) cell_op[i] = deq_pkg::CELL_FROM_NEXT;
                count_nxt = cnt_m1;
              end
            end
            deq_pkg::KIND_POP_BACK: begin
              if (count_r == '0) begin
                out_status_nxt = deq_pkg::ST_EMPTY;
              end else begin
                out_element_nxt = cell_word[cnt_m1[IW-1:0]];
                count_nxt = cnt_m1;
              end
            end
            deq_pkg::KIND_DUMP: begin
              if (count_r == '0) out_status_nxt = deq_pkg::ST_EMPTY;
              else begin
                // results follow from the dump state
                out_valid_nxt = 1'b0;
                rem_nxt       = count_r;
              end
            end
            default: ;
          endcase
          out_occupancy_nxt = 5'(count_nxt);
        end
      end
      deq_pkg::S_DUMP: begin
        if (out_free) begin
          // emit the front word and rotate the occupied cells by one
          out_valid_nxt     = 1'b1;
          out_status_nxt    = deq_pkg::ST_OK;
          out_element_nxt   = cell_word[0];
          out_occupancy_nxt = 5'(count_r);
          out_last_nxt      = (rem_r == CW'(1));
          load_bus          = cell_word[0];
          for (int i = 0; i < CAPACITY; i++) begin
            if (CW'(i) < cnt_m1) cell_op[i] = deq_pkg::CELL_FROM_NEXT;
            else if (CW'(i) == cnt_m1) cell_op[i] = deq_pkg::CELL_LOAD;
          end
          rem_nxt = rem_r - CW'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= deq_pkg::S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_status_r    <= out_status_nxt;
    out_element_r   <= out_element_nxt;
    out_occupancy_r <= out_occupancy_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_element   = out_element_r;
  assign out_occupancy = out_occupancy_r;
  assign out_last      = out_last_r;

endmodule

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// tb: testbench for deque_with_positional_insert_top
// A directed table of command words comes first: empty pops and dumps, the
// bad position, value extremes, a fill to capacity and inserts into the full
// store. Random phases follow that grow, mix and drain the store. Each result
// word is checked against a deque model kept inside the bench. Both channels
// idle at random, the result side holds off once for a long stretch, and the
// command side waits out everything in flight after the table and once more.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int CAP         = 16;
  localparam int RAND_WORDS  = 170;
  localparam int PHASE_LEN   = 25;
  localparam int HOLD_AT     = 70;
  localparam int HOLD_LEN    = 60;
  localparam int QUIET_LIMIT = 500;
  localparam int TAIL_CYCLES = 20;

  // command codes the block leaves unused
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  // flavor of a random phase
  typedef enum int {MODE_GROW, MODE_MIXED, MODE_SHRINK} mode_t;

  typedef struct packed {
    status_t    st;
    word_t      elem;
    logic [4:0] occ;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [2:0] kind;
    word_t      value;
    logic [7:0] pos;
    logic       typed;
    res_t       want;
  } row_t;

  localparam res_t NO_CHECK = '0;

  // directed commands; rows with typed set carry their result word
  localparam row_t DIR_TAB [27] = '{
    '{KIND_POP_FRONT,  32'sh0,        8'd0,   1'b1, '{ST_EMPTY,  32'sh0, 5'd0,  1'b1}},
    '{KIND_POP_BACK,   32'sh0,        8'd0,   1'b1, '{ST_EMPTY,  32'sh0, 5'd0,  1'b1}},
    '{KIND_DUMP,       32'sh0,        8'd0,   1'b1, '{ST_EMPTY,  32'sh0, 5'd0,  1'b1}},
    '{KIND_INSERT_POS, 32'sh11,       8'd0,   1'b1, '{ST_BADPOS, 32'sh0, 5'd0,  1'b1}},
    '{KIND_PUSH_BACK,  32'sh7fffffff, 8'd0,   1'b1, '{ST_OK,     32'sh0, 5'd1,  1'b1}},
    '{KIND_PUSH_FRONT, 32'sh80000000, 8'd0,   1'b1, '{ST_OK,     32'sh0, 5'd2,  1'b1}},
    '{KIND_INSERT_POS, 32'shffffffff, 8'd255, 1'b1, '{ST_OK,     32'sh0, 5'd3,  1'b1}},
    '{KIND_INSERT_POS, 32'sh5555aaaa, 8'd1,   1'b0, NO_CHECK},
    '{KIND_INSERT_POS, 32'shaaaa5555, 8'd3,   1'b0, NO_CHECK},
    '{KIND_INSERT_POS, 32'sh1,        8'd5,   1'b0, NO_CHECK},
    '{KIND_INSERT_POS, 32'sh2,        8'd7,   1'b0, NO_CHECK},
    '{KIND_PUSH_FRONT, 32'sh0,        8'd0,   1'b0, NO_CHECK},
    '{KIND_PUSH_BACK,  32'sh0000ffff, 8'd0,   1'b0, NO_CHECK},
    '{KIND_INSERT_POS, 32'shffff0000, 8'd2,   1'b0, NO_CHECK},
    '{KIND_PUSH_BACK,  32'sh12345678, 8'd0,   1'b0, NO_CHECK},
    '{KIND_PUSH_FRONT, 32'sh87654321, 8'd0,   1'b0, NO_CHECK},
    '{KIND_INSERT_POS, 32'sh3,        8'd128, 1'b0, NO_CHECK},
    '{KIND_PUSH_BACK,  32'sh4,        8'd0,   1'b0, NO_CHECK},
    '{KIND_INSERT_POS, 32'sh5,        8'd9,   1'b0, NO_CHECK},
    '{KIND_PUSH_FRONT, 32'sh6,        8'd0,   1'b0, NO_CHECK},
    '{KIND_PUSH_BACK,  32'sh7,        8'd0,   1'b1, '{ST_FULL,   32'sh0, 5'd16, 1'b1}},
    '{KIND_INSERT_POS, 32'sh8,        8'd0,   1'b1, '{ST_BADPOS, 32'sh0, 5'd16, 1'b1}},
    '{KIND_DUMP,       32'sh0,        8'd0,   1'b0, NO_CHECK},
    '{KIND_SPARE_A,    32'shffffffff, 8'd255, 1'b1, '{ST_OK,     32'sh0, 5'd16, 1'b1}},
    '{KIND_POP_FRONT,  32'sh9,        8'd0,   1'b0, NO_CHECK},
    '{KIND_POP_BACK,   32'sh0,        8'd0,   1'b0, NO_CHECK},
    '{KIND_SPARE_B,    32'sh0,        8'd0,   1'b1, '{ST_OK,     32'sh0, 5'd14, 1'b1}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind = '0;
  word_t       in_value = '0;
  logic [7:0]  in_position = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  word_t       out_element;
  logic [4:0]  out_occupancy;
  logic        out_last;

  // bench copy of the store and the results still owed by the block
  word_t cells [CAP];
  int    stored = 0;
  res_t  results_due [$];
  int    mismatches = 0;
  int    words_sent = 0;
  bit    tx_quiet = 1'b0;

  deque_with_positional_insert_top #(.CAPACITY(CAP)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_value      (in_value),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_element   (out_element),
    .out_occupancy (out_occupancy),
    .out_last      (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void note_result(status_t st, word_t elem, logic last);
    results_due.push_back(res_t'{st, elem, 5'(stored), last});
  endfunction

  // Apply one command to the bench store and queue the result words it owes
  function automatic void apply_command(logic [2:0] kind, word_t value, logic [7:0] pos);
    int    slot;
    word_t taken;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INSERT_POS: begin
        // bad position wins over full
        if (kind == KIND_INSERT_POS && pos == 8'd0) begin
          note_result(ST_BADPOS, '0, 1'b1);
        end else if (stored == CAP) begin
          note_result(ST_FULL, '0, 1'b1);
        end else begin
          if (kind == KIND_PUSH_FRONT) slot = 0;
          else if (kind == KIND_PUSH_BACK) slot = stored;
          else slot = (int'(pos) - 1 < stored) ? int'(pos) - 1 : stored;
          for (int i = stored; i > slot; i--) cells[i] = cells[i - 1];
          cells[slot] = value;
          stored++;
          note_result(ST_OK, '0, 1'b1);
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (stored == 0) begin
          note_result(ST_EMPTY, '0, 1'b1);
        end else begin
          if (kind == KIND_POP_FRONT) begin
            taken = cells[0];
            for (int i = 1; i < stored; i++) cells[i - 1] = cells[i];
          end else begin
            taken = cells[stored - 1];
          end
          stored--;
          note_result(ST_OK, taken, 1'b1);
        end
      end
      KIND_DUMP: begin
        if (stored == 0) begin
          note_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < stored; i++) note_result(ST_OK, cells[i], i == stored - 1);
        end
      end
      // unused codes: one plain ok word, store untouched
      default: note_result(ST_OK, '0, 1'b1);
    endcase
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
  endfunction

  // Offer one command word; called and returns at a falling edge, valid left high
  task automatic send_word(row_t w);
    int gap;
    gap = tx_quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= w.kind;
    in_value    <= w.value;
    in_position <= w.pos;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    apply_command(w.kind, w.value, w.pos);
    if (w.typed) results_due[results_due.size() - 1] = w.want;
    words_sent++;
    @(negedge clk);
  endtask

  // Command side: directed table, then random phases
  initial begin : stimulus
    row_t  w;
    mode_t mode;
    int    counted;
    int    phase;
    int    roll;
    int    pick;
    int    ins_pct;
    counted = 0;
    phase = -1;
    mode = MODE_GROW;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIR_TAB[i]) send_word(DIR_TAB[i]);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    @(negedge clk);

    while (counted < RAND_WORDS) begin
      if (counted / PHASE_LEN != phase) begin
        phase = counted / PHASE_LEN;
        mode = mode_t'(phase % 3);
        tx_quiet = (phase % 4 == 3);
        // once: let everything in flight come out before going on
        if (phase == 4) begin
          in_valid <= 1'b0;
          while (results_due.size() != 0) @(posedge clk);
          @(negedge clk);
        end
      end

      ins_pct = (mode == MODE_GROW) ? 80 : (mode == MODE_SHRINK) ? 20 : 50;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        w.kind = roll[0] ? KIND_SPARE_A : KIND_SPARE_B;
      end else if (roll < 10) begin
        w.kind = KIND_DUMP;
      end else if (roll < 10 + ins_pct * 9 / 10) begin
        pick = $urandom_range(0, 2);
        w.kind = (pick == 0) ? KIND_PUSH_FRONT :
                 (pick == 1) ? KIND_PUSH_BACK : KIND_INSERT_POS;
      end else begin
        w.kind = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
      end

      // positions mostly inside the store or one past it
      roll = $urandom_range(0, 19);
      if (roll == 0) w.pos = '0;
      else if (roll < 4) w.pos = 8'($urandom);
      else w.pos = 8'($urandom_range(1, stored + 1));

      roll = $urandom_range(0, 19);
      if (roll == 0) w.value = 32'sh7fffffff;
      else if (roll == 1) w.value = 32'sh80000000;
      else w.value = $urandom;

      w.typed = 1'b0;
      w.want = NO_CHECK;
      send_word(w);
      if (w.kind != KIND_SPARE_A && w.kind != KIND_SPARE_B) counted++;
    end
    in_valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Result side stall: random runs, plus one long hold while commands keep coming
  initial begin : result_stall
    int len;
    bit long_hold_done;
    long_hold_done = 1'b0;
    @(negedge clk);
    forever begin
      if (!long_hold_done && words_sent >= HOLD_AT) begin
        long_hold_done = 1'b1;
        len = HOLD_LEN;
      end else begin
        len = gap_len();
      end
      if (len > 0) begin
        out_stall <= 1'b1;
        repeat (len) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  end

  // Capture each accepted result word at the rising edge, compare it at the falling edge
  initial begin : result_check
    res_t seen;
    res_t want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        seen = res_t'{status_t'(out_status), out_element, out_occupancy, out_last};
        @(negedge clk);
        if (results_due.size() == 0) begin
          flag_error($sformatf("unexpected word: status %0d element %h occupancy %0d last %0b",
                               seen.st, seen.elem, seen.occ, seen.last));
        end else begin
          want = results_due.pop_front();
          if (seen.st !== want.st || seen.elem !== want.elem ||
              seen.occ !== want.occ || seen.last !== want.last) begin
            flag_error($sformatf({"expected status %0d element %h occupancy %0d last %0b, ",
                                  "got status %0d element %h occupancy %0d last %0b"},
                                 want.st, want.elem, want.occ, want.last,
                                 seen.st, seen.elem, seen.occ, seen.last));
          end
        end
      end
    end
  end

  // Watchdog: too many cycles with no word moving on either channel
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
